@@ sv/dirr_pkg.sv @@
// ----------------------------------------------------------------------------
// dirr_pkg
// Shared types, constants and rounding helpers for the dielectric scatter unit
// ----------------------------------------------------------------------------
package dirr_pkg;

  // Q.16 one and output range
  localparam int unsigned One16  = 65536;
  localparam int          OutMax = 16384;

  // index register
  localparam int unsigned IorW     = 14;
  localparam logic [IorW-1:0] IorReset = 14'd6144;

  // eta in Q.16, saturated to 20 bits
  localparam int unsigned EtaW = 20;
  localparam logic [EtaW-1:0] EtaMax = 20'hFFFFF;
  localparam int unsigned R0W  = 17;

  // config divider
  localparam int unsigned DivDw    = 37;
  localparam int unsigned DivVw    = 21;
  localparam int unsigned DivSteps = DivDw;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // square root pipeline
  localparam int unsigned SqW   = 50;
  localparam int unsigned SqTop = 48;
  localparam int unsigned SqN   = SqTop / 2 + 1;
  localparam int unsigned SqRw  = 25;

  // derived config values
  typedef struct packed {
    logic [EtaW-1:0] eta_in;
    logic [EtaW-1:0] eta_out;
    logic [R0W-1:0]  r0_in;
    logic [R0W-1:0]  r0_out;
    logic            busy;
  } cfg_res_t;

  // word side data carried through the square root
  typedef struct packed {
    logic [2:0][15:0] n;
    logic [2:0][36:0] ed;
    logic [2:0][15:0] ro;
    logic [25:0]      etadn;
    logic             refl;
    logic             kneg;
  } side_t;

  // shift right, round half away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                             input int unsigned s);
    logic [63:0] h;
    logic [63:0] m;
    h = 64'd1 << (s - 1);
    m = 64'(-v);
    if (!v[63]) begin
      rshr = $signed((64'(v) + h) >> s);
    end else begin
      rshr = -$signed((m + h) >> s);
    end
  endfunction

  // saturate to the Q1.14 unit range
  function automatic logic signed [15:0] sat14(input logic signed [63:0] v);
    if (v > 64'sd16384) begin
      sat14 = 16'sd16384;
    end else if (v < -64'sd16384) begin
      sat14 = -16'sd16384;
    end else begin
      sat14 = v[15:0];
    end
  endfunction

endpackage

@@ sv/dielectric_reflect_refract.sv @@
// ----------------------------------------------------------------------------
// dielectric_reflect_refract
// Dielectric scatter: Schlick reflectance, mirror reflection or Snell refraction
// ----------------------------------------------------------------------------
// pipeline: 7 front stages, the 25-stage square root and 3 back stages
// throughput: one word per cycle while the divider sequencer is idle; the whole pipe holds while the output stalls
// reset: index returns to 1.5; after reset and after each index write the
//   divider sequencer derives eta and r0 with in_ready_o low
// ----------------------------------------------------------------------------
module dielectric_reflect_refract import dirr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IorW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  in_dir_x_i,
  input  logic signed [15:0]  in_dir_y_i,
  input  logic signed [15:0]  in_dir_z_i,
  input  logic signed [15:0]  normal_x_i,
  input  logic signed [15:0]  normal_y_i,
  input  logic signed [15:0]  normal_z_i,
  input  logic                inside_medium_i,
  input  logic [15:0]         random_fraction_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  out_dir_x_o,
  output logic signed [15:0]  out_dir_y_o,
  output logic signed [15:0]  out_dir_z_o,
  output logic                was_reflected_o
);

  cfg_res_t cfg;
  logic     en;
  logic signed [15:0] din [3];
  logic signed [15:0] nin [3];

  dirr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // pipe advance
  logic vj_q;
  assign en         = !vj_q || out_ready_i;
  assign in_ready_o = en && !cfg.busy;

  assign din[0] = in_dir_x_i;
  assign din[1] = in_dir_y_i;
  assign din[2] = in_dir_z_i;
  assign nin[0] = normal_x_i;
  assign nin[1] = normal_y_i;
  assign nin[2] = normal_z_i;

  // stage registers
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q, vi_q;

  logic signed [15:0] a_d_q [3];
  logic signed [15:0] a_n_q [3];
  logic signed [31:0] a_p_q [3];
  logic [15:0]        a_rnd_q;
  logic [EtaW-1:0]    a_eta_q;
  logic [R0W-1:0]     a_r0_q;

  logic signed [15:0] b_d_q [3];
  logic signed [15:0] b_n_q [3];
  logic signed [33:0] b_dot_q;
  logic [15:0]        b_rnd_q;
  logic [EtaW-1:0]    b_eta_q;
  logic [23:0]        b_eta2_q;
  logic [R0W-1:0]     b_r02_q;

  logic signed [15:0] c_d_q [3];
  logic signed [15:0] c_n_q [3];
  logic signed [33:0] c_dot_q;
  logic signed [21:0] c_dn_q;
  logic signed [17:0] c_c16_q;
  logic [15:0]        c_rnd_q;
  logic [EtaW-1:0]    c_eta_q;
  logic [23:0]        c_eta2_q;
  logic [R0W-1:0]     c_r02_q;

  logic signed [15:0] d_d_q [3];
  logic signed [15:0] d_n_q [3];
  logic signed [49:0] d_rp_q [3];
  logic [17:0]        d_t_q;
  logic [18:0]        d_p2_q;
  logic [16:0]        d_s2_q;
  logic signed [24:0] d_onem_q;
  logic signed [25:0] d_etadn_q;
  logic [15:0]        d_rnd_q;
  logic [EtaW-1:0]    d_eta_q;
  logic [23:0]        d_eta2_q;
  logic [R0W-1:0]     d_r02_q;

  logic signed [15:0] e_n_q [3];
  logic signed [36:0] e_ed_q [3];
  logic signed [15:0] e_ro_q [3];
  logic [20:0]        e_p4_q;
  logic               e_tir_q;
  logic signed [49:0] e_eprod_q;
  logic [17:0]        e_t_q;
  logic [R0W-1:0]     e_r02_q;
  logic [15:0]        e_rnd_q;
  logic signed [25:0] e_etadn_q;

  logic signed [15:0] f_n_q [3];
  logic signed [36:0] f_ed_q [3];
  logic signed [15:0] f_ro_q [3];
  logic [21:0]        f_p5_q;
  logic signed [33:0] f_k_q;
  logic               f_tir_q;
  logic [R0W-1:0]     f_r02_q;
  logic [15:0]        f_rnd_q;
  logic signed [25:0] f_etadn_q;

  logic signed [15:0] g_n_q [3];
  logic signed [36:0] g_ed_q [3];
  logic signed [15:0] g_ro_q [3];
  logic [22:0]        g_rth_q;
  logic signed [33:0] g_k_q;
  logic               g_tir_q;
  logic [15:0]        g_rnd_q;
  logic signed [25:0] g_etadn_q;

  logic signed [26:0] h_coef_q;
  side_t              h_side_q;
  logic signed [42:0] i_cn_q [3];
  side_t              i_side_q;
  logic signed [15:0] j_o_q [3];
  logic               j_refl_q;

  // square root hookup
  side_t           sq_side_in;
  side_t           sq_side_out;
  logic [SqW-1:0]  sq_x;
  logic            sq_valid;
  logic [SqRw-1:0] sq_root;
  logic            g_kneg;

  assign g_kneg = g_k_q[33];
  assign sq_x   = g_kneg ? '0 : (SqW'(g_k_q[32:0]) << 16);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_side_in.n[i]  = g_n_q[i];
      sq_side_in.ed[i] = g_ed_q[i];
      sq_side_in.ro[i] = g_ro_q[i];
    end
    sq_side_in.etadn = g_etadn_q;
    sq_side_in.refl  = g_tir_q || ({7'b0, g_rnd_q} < g_rth_q);
    sq_side_in.kneg  = g_kneg;
  end

  dirr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vg_q),
    .x_i     (sq_x),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side_out)
  );

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i && !cfg.busy;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= sq_valid;
      vi_q <= vh_q;
      vj_q <= vi_q;
    end
  end

  // stage c combinational: rounded dot and clamped cosine
  logic signed [21:0] dn_c;
  logic signed [22:0] ndn_c;
  logic signed [17:0] c16_c;
  always_comb begin
    dn_c  = 22'(rshr(64'(b_dot_q), 12));
    ndn_c = -(23'(dn_c));
    if (ndn_c > 23'sd65536) begin
      c16_c = 18'sd65536;
    end else if (ndn_c < -23'sd65536) begin
      c16_c = -18'sd65536;
    end else begin
      c16_c = ndn_c[17:0];
    end
  end

  // stage d combinational: powers and squares
  logic signed [18:0] t_c;
  logic [35:0]        csq_c;
  logic [43:0]        dnsq_c;
  logic [23:0]        dn2_c;
  always_comb begin
    t_c    = 19'sd65536 - 19'(c_c16_q);
    csq_c  = 36'(c_c16_q * c_c16_q);
    dnsq_c = 44'(44'(c_dn_q) * 44'(c_dn_q));
    dn2_c  = 24'((dnsq_c + 44'd32768) >> 16);
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage a: component products, eta and r0 select
      for (int i = 0; i < 3; i++) begin
        a_d_q[i] <= din[i];
        a_n_q[i] <= nin[i];
        a_p_q[i] <= din[i] * nin[i];
      end
      a_rnd_q <= random_fraction_i;
      a_eta_q <= inside_medium_i ? cfg.eta_in : cfg.eta_out;
      a_r0_q  <= inside_medium_i ? cfg.r0_in : cfg.r0_out;

      // stage b: dot product, eta squared, r0 squared
      b_d_q    <= a_d_q;
      b_n_q    <= a_n_q;
      b_dot_q  <= 34'(a_p_q[0]) + 34'(a_p_q[1]) + 34'(a_p_q[2]);
      b_rnd_q  <= a_rnd_q;
      b_eta_q  <= a_eta_q;
      b_eta2_q <= 24'((40'(a_eta_q) * 40'(a_eta_q) + 40'd32768) >> 16);
      b_r02_q  <= R0W'((34'(a_r0_q) * 34'(a_r0_q) + 34'd32768) >> 16);

      // stage c: cosine
      c_d_q    <= b_d_q;
      c_n_q    <= b_n_q;
      c_dot_q  <= b_dot_q;
      c_dn_q   <= dn_c;
      c_c16_q  <= c16_c;
      c_rnd_q  <= b_rnd_q;
      c_eta_q  <= b_eta_q;
      c_eta2_q <= b_eta2_q;
      c_r02_q  <= b_r02_q;

      // stage d: (1-cos)^2, sin^2, 1-dn^2, eta*dn, mirror products
      d_d_q <= c_d_q;
      d_n_q <= c_n_q;
      for (int i = 0; i < 3; i++) begin
        d_rp_q[i] <= 50'(64'(c_dot_q) * 64'(c_n_q[i]));
      end
      d_t_q     <= t_c[17:0];
      d_p2_q    <= 19'((36'(t_c[17:0]) * 36'(t_c[17:0]) + 36'd32768) >> 16);
      d_s2_q    <= 17'((37'd4294967296 - 37'(csq_c) + 37'd32768) >> 16);
      d_onem_q  <= 25'(26'sd65536 - $signed({2'b00, dn2_c}));
      d_etadn_q <= 26'(rshr(64'($signed({1'b0, c_eta_q})) * 64'(c_dn_q), 16));
      d_rnd_q   <= c_rnd_q;
      d_eta_q   <= c_eta_q;
      d_eta2_q  <= c_eta2_q;
      d_r02_q   <= c_r02_q;

      // stage e: ^4, internal reflection test, refraction products, mirror
      e_n_q <= d_n_q;
      for (int i = 0; i < 3; i++) begin
        e_ed_q[i] <= 37'(64'($signed({1'b0, d_eta_q})) * 64'(d_d_q[i]));
        e_ro_q[i] <= sat14(rshr((64'(d_d_q[i]) <<< 28) - (64'(d_rp_q[i]) <<< 1), 28));
      end
      e_p4_q    <= 21'((42'(d_p2_q) * 42'(d_p2_q) + 42'd32768) >> 16);
      e_tir_q   <= (41'(d_s2_q) * 41'(d_eta2_q)) > 41'd4294967296;
      e_eprod_q <= 50'(64'(d_onem_q) * 64'($signed({1'b0, d_eta2_q})));
      e_t_q     <= d_t_q;
      e_r02_q   <= d_r02_q;
      e_rnd_q   <= d_rnd_q;
      e_etadn_q <= d_etadn_q;

      // stage f: ^5 and k
      f_n_q     <= e_n_q;
      f_ed_q    <= e_ed_q;
      f_ro_q    <= e_ro_q;
      f_p5_q    <= 22'((40'(e_p4_q) * 40'(e_t_q) + 40'd32768) >> 16);
      f_k_q     <= 34'(64'sd65536 - rshr(64'(e_eprod_q), 16));
      f_tir_q   <= e_tir_q;
      f_r02_q   <= e_r02_q;
      f_rnd_q   <= e_rnd_q;
      f_etadn_q <= e_etadn_q;

      // stage g: reflectance threshold
      g_n_q     <= f_n_q;
      g_ed_q    <= f_ed_q;
      g_ro_q    <= f_ro_q;
      g_rth_q   <= 23'(40'(f_r02_q) + ((40'(R0W'(One16) - f_r02_q) * 40'(f_p5_q)
                   + 40'd32768) >> 16));
      g_k_q     <= f_k_q;
      g_tir_q   <= f_tir_q;
      g_rnd_q   <= f_rnd_q;
      g_etadn_q <= f_etadn_q;

      // stage h: normal coefficient
      h_coef_q <= 27'(64'($signed(sq_side_out.etadn)) + 64'({1'b0, sq_root}));
      h_side_q <= sq_side_out;

      // stage i: coefficient times normal
      for (int i = 0; i < 3; i++) begin
        i_cn_q[i] <= 43'(64'(h_coef_q) * 64'($signed(h_side_q.n[i])));
      end
      i_side_q <= h_side_q;

      // stage j: output word
      for (int i = 0; i < 3; i++) begin
        if (i_side_q.refl) begin
          j_o_q[i] <= $signed(i_side_q.ro[i]);
        end else if (i_side_q.kneg) begin
          j_o_q[i] <= '0;
        end else begin
          j_o_q[i] <= sat14(rshr(64'($signed(i_side_q.ed[i])) - 64'(i_cn_q[i]), 16));
        end
      end
      j_refl_q <= i_side_q.refl;
    end
  end

  assign out_valid_o     = vj_q;
  assign out_dir_x_o     = j_o_q[0];
  assign out_dir_y_o     = j_o_q[1];
  assign out_dir_z_o     = j_o_q[2];
  assign was_reflected_o = j_refl_q;

endmodule

@@ sv/dirr_cfg.sv @@
// ----------------------------------------------------------------------------
// dirr_cfg
// Index register and sequencer deriving eta and r0 with a bit-serial divider
// ----------------------------------------------------------------------------
module dirr_cfg import dirr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IorW-1:0] cfg_wdata_i,
  output cfg_res_t        cfg_o
);

  localparam logic [2:0] StLd1  = 3'd0;
  localparam logic [2:0] StRun1 = 3'd1;
  localparam logic [2:0] StLd2  = 3'd2;
  localparam logic [2:0] StRun2 = 3'd3;
  localparam logic [2:0] StLd3  = 3'd4;
  localparam logic [2:0] StRun3 = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [IorW-1:0]    ior_q;
  logic [2:0]         state_q;
  logic [DivDw-1:0]   dvd_q;
  logic [DivVw-1:0]   dvs_q;
  logic [DivVw:0]     rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic [EtaW-1:0]    eta_out_q;
  logic [R0W-1:0]     r0_out_q;
  logic [R0W-1:0]     r0_in_q;

  logic [EtaW-1:0]  eta_in;
  logic [EtaW-1:0]  eta_sel;
  logic [DivVw-1:0] num;
  logic [DivVw-1:0] den;
  logic [DivVw:0]   rem_sh;
  logic             ge;
  logic [DivVw:0]   rem_nx;
  logic [DivDw-1:0] dvd_nx;
  logic             last;

  assign eta_in = EtaW'({ior_q, 4'b0000});

  // r0 operands
  assign eta_sel = (state_q == StLd2) ? eta_out_q : eta_in;
  assign num = (eta_sel > EtaW'(One16)) ? DivVw'(eta_sel) - DivVw'(One16)
                                        : DivVw'(One16) - DivVw'(eta_sel);
  assign den = DivVw'(One16) + DivVw'(eta_sel);

  // one restoring divide step
  assign rem_sh = {rem_q[DivVw-1:0], dvd_q[DivDw-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  assign dvd_nx = {dvd_q[DivDw-2:0], ge};
  assign last   = cnt_q == DivCntW'(DivSteps - 1);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ior_q     <= IorReset;
      state_q   <= StLd1;
      dvd_q     <= '0;
      dvs_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      eta_out_q <= '0;
      r0_out_q  <= '0;
      r0_in_q   <= '0;
    end else if (cfg_we_i) begin
      ior_q   <= cfg_wdata_i;
      state_q <= StLd1;
    end else begin
      unique case (state_q)
        StLd1: begin
          dvd_q   <= DivDw'(29'd268435456) + DivDw'(ior_q >> 1);
          dvs_q   <= DivVw'(ior_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= StRun1;
        end
        StLd2, StLd3: begin
          dvd_q   <= {num[DivDw-17:0], 16'h0000} + DivDw'(den >> 1);
          dvs_q   <= den;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= (state_q == StLd2) ? StRun2 : StRun3;
        end
        StRun1, StRun2, StRun3: begin
          dvd_q <= dvd_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q + 1'b1;
          if (last) begin
            if (state_q == StRun1) begin
              eta_out_q <= (dvd_nx > DivDw'(EtaMax)) ? EtaMax : dvd_nx[EtaW-1:0];
              state_q   <= StLd2;
            end else if (state_q == StRun2) begin
              r0_out_q <= dvd_nx[R0W-1:0];
              state_q  <= StLd3;
            end else begin
              r0_in_q <= dvd_nx[R0W-1:0];
              state_q <= StDone;
            end
          end
        end
        default: begin
          state_q <= StDone;
        end
      endcase
    end
  end

  assign cfg_o.eta_in  = eta_in;
  assign cfg_o.eta_out = eta_out_q;
  assign cfg_o.r0_in   = r0_in_q;
  assign cfg_o.r0_out  = r0_out_q;
  assign cfg_o.busy    = state_q != StDone;

endmodule

@@ sv/dirr_sqrt.sv @@
// ----------------------------------------------------------------------------
// dirr_sqrt
// Pipelined integer floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module dirr_sqrt import dirr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [SqW-1:0]  x_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [SqRw-1:0] root_o,
  output side_t           side_o
);

  logic [SqW-1:0] x_q    [SqN];
  logic [SqW-1:0] r_q    [SqN];
  side_t          side_q [SqN];
  logic           v_q    [SqN];

  for (genvar i = 0; i < SqN; i++) begin : g_stage
    logic [SqW-1:0] xin;
    logic [SqW-1:0] rin;
    logic [SqW-1:0] bitv;
    logic [SqW-1:0] trial;
    logic [SqW-1:0] xout;
    logic [SqW-1:0] rout;
    side_t          sin;
    logic           vin;

    if (i == 0) begin : g_first
      assign xin = x_i;
      assign rin = '0;
      assign sin = side_i;
      assign vin = valid_i;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign rin = r_q[i-1];
      assign sin = side_q[i-1];
      assign vin = v_q[i-1];
    end

    // digit decision
    assign bitv  = SqW'(1) << (SqTop - 2 * i);
    assign trial = rin + bitv;
    always_comb begin
      if (xin >= trial) begin
        xout = xin - trial;
        rout = (rin >> 1) + bitv;
      end else begin
        xout = xin;
        rout = rin >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= xout;
        r_q[i]    <= rout;
        side_q[i] <= sin;
      end
    end
  end

  assign valid_o = v_q[SqN-1];
  assign root_o  = r_q[SqN-1][SqRw-1:0];
  assign side_o  = side_q[SqN-1];

endmodule
